// ===== rtl/fals_pkg.sv =====
// ----------------------------------------------------------------------------
// fals_pkg
// Shared types, sizes, codes and arithmetic helpers of the forced-alignment
// log-domain score block.
// ----------------------------------------------------------------------------
package fals_pkg;

	localparam int MAX_CLASSES = 32;
	localparam int CLASS_W     = $clog2(MAX_CLASSES);
	localparam int MAX_TARGETS = 64;
	localparam int POS_W       = $clog2(MAX_TARGETS);
	localparam int MAX_FRAMES  = 4096;
	localparam int FRAME_W     = $clog2(MAX_FRAMES);
	localparam int CNT_W       = 13;
	localparam int TLEN_W      = 7;
	localparam int SCALE_W     = 17;
	localparam int VAL_W       = 24;
	localparam int ALPHA_W     = 40;
	localparam int FRAC_W      = 16;
	localparam int SUM_W       = ALPHA_W + 2;
	localparam int TRANS_DEPTH = MAX_CLASSES * MAX_CLASSES;
	localparam int NUM_STAGES  = 6;
	localparam int RING_LEN    = MAX_TARGETS + NUM_STAGES;
	localparam int ROT_W       = $clog2(RING_LEN);
	localparam int TAB_W       = 16;
	localparam int IFRAC_W     = 14;

	// request kinds
	localparam logic [1:0] REQ_LABEL = 2'd0;
	localparam logic [1:0] REQ_TRANS = 2'd1;
	localparam logic [1:0] REQ_EMIS  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_FRAME_COUNT   = 2'd0;
	localparam logic [1:0] REG_TARGET_LENGTH = 2'd1;
	localparam logic [1:0] REG_SCORE_SCALE   = 2'd2;

	typedef logic signed [ALPHA_W-1:0] alpha_t;
	typedef logic signed [VAL_W-1:0]   val_t;

	// one ring slot: a target label and its alpha
	typedef struct packed {
		logic [CLASS_W-1:0] label;
		alpha_t             alpha;
	} item_t;

	// update kind of one target position
	typedef enum logic [2:0] {
		MODE_KEEP,
		MODE_EMIS,
		MODE_SELF,
		MODE_LSE,
		MODE_PREV
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic  cap;
	} ctl_t;

	// clamp a grown sum to the alpha range
	function automatic alpha_t sat40(input logic signed [SUM_W-1:0] x);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = {3'b000, {(ALPHA_W-1){1'b1}}};
		lo = {3'b111, {(ALPHA_W-1){1'b0}}};
		if (x > hi) return {1'b0, {(ALPHA_W-1){1'b1}}};
		if (x < lo) return {1'b1, {(ALPHA_W-1){1'b0}}};
		return x[ALPHA_W-1:0];
	endfunction

	// ln(1+exp(-x)) in Q16 at x = k/4
	function automatic logic [TAB_W-1:0] lse_tab(input logic [5:0] k);
		logic [TAB_W-1:0] r;
		unique case (k)
			6'd0:  r = 16'd45426;
			6'd1:  r = 16'd37745;
			6'd2:  r = 16'd31069;
			6'd3:  r = 16'd25354;
			6'd4:  r = 16'd20530;
			6'd5:  r = 16'd16510;
			6'd6:  r = 16'd13200;
			6'd7:  r = 16'd10500;
			6'd8:  r = 16'd8318;
			6'd9:  r = 16'd6567;
			6'd10: r = 16'd5170;
			6'd11: r = 16'd4061;
			6'd12: r = 16'd3184;
			6'd13: r = 16'd2493;
			6'd14: r = 16'd1950;
			6'd15: r = 16'd1523;
			6'd16: r = 16'd1189;
			6'd17: r = 16'd928;
			6'd18: r = 16'd724;
			6'd19: r = 16'd565;
			6'd20: r = 16'd440;
			6'd21: r = 16'd343;
			6'd22: r = 16'd267;
			6'd23: r = 16'd208;
			6'd24: r = 16'd162;
			6'd25: r = 16'd126;
			6'd26: r = 16'd98;
			6'd27: r = 16'd77;
			6'd28: r = 16'd60;
			6'd29: r = 16'd47;
			6'd30: r = 16'd36;
			6'd31: r = 16'd28;
			6'd32: r = 16'd22;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/fals_ram.sv =====
// ----------------------------------------------------------------------------
// fals_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fals_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/fals_cell.sv =====
// ----------------------------------------------------------------------------
// fals_cell
// One slot of the alpha ring: holds a target label and its alpha, passes
// both to its neighbor on every shift.
// ----------------------------------------------------------------------------
module fals_cell import fals_pkg::*; (
	input  logic               clk,
	input  logic               shift_en,
	input  logic               label_we,
	input  logic [CLASS_W-1:0] label_in,
	input  item_t              d,
	output item_t              q
);

	item_t slot_q;

	// shift along the ring, or take a label write while parked
	always_ff @(posedge clk) begin
		if (shift_en) begin
			slot_q <= d;
		end else if (label_we) begin
			slot_q.label <= label_in;
		end
	end

	assign q = slot_q;

endmodule

// ===== rtl/fals_step.sv =====
// ----------------------------------------------------------------------------
// fals_step
// Six-stage update unit closing the alpha ring: transition lookup, the two
// saturated candidate sums, table-corrected log-sum-exp and emission add.
// ----------------------------------------------------------------------------
module fals_step import fals_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 shift_en,
	input  item_t                head,
	input  ctl_t                 head_ctl,
	input  val_t                 head_emis,
	input  logic                 tr_we,
	input  logic [2*CLASS_W-1:0] tr_addr,
	input  val_t                 tr_data,
	output item_t                tail,
	output ctl_t                 tail_ctl
);

	item_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6;
	ctl_t  ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	alpha_t ap_s1;
	val_t  e_s1, e_s2, e_s3, e_s4, e_s5;
	alpha_t x1_s2, x2_s2;
	alpha_t dir_s2, dir_s3, dir_s4, dir_s5;
	alpha_t m_s3, m_s4;
	logic  far_s3, far_s4;
	logic [CLASS_W-1:0] k_s3;
	logic [IFRAC_W-1:0] frac_s3;
	logic [TAB_W-1:0] tk_s4, sub_s4;
	alpha_t lse_s5;

	logic [VAL_W-1:0] ts_raw, tp_raw;
	logic signed [SUM_W-1:0] ts_w, tp_w, a_w, ap_w, e1_w;
	alpha_t x1_c, x2_c, dir_c;
	logic [ALPHA_W:0] dmag_c;
	logic [TAB_W-1:0] tk_c, tn_c, td_c, corr_c;
	logic [TAB_W+IFRAC_W-1:0] prod_c;
	alpha_t lse_c, res_c;

	// transition reads: self entry and previous-label entry
	fals_ram #(.WIDTH(VAL_W), .DEPTH(TRANS_DEPTH)) u_self_ram (
		.clk   (clk),
		.we    (tr_we),
		.waddr (tr_addr),
		.wdata (tr_data),
		.re    (shift_en),
		.raddr ({head.label, head.label}),
		.rdata (ts_raw)
	);

	fals_ram #(.WIDTH(VAL_W), .DEPTH(TRANS_DEPTH)) u_prev_ram (
		.clk   (clk),
		.we    (tr_we),
		.waddr (tr_addr),
		.wdata (tr_data),
		.re    (shift_en),
		.raddr ({head.label, it_s1.label}),
		.rdata (tp_raw)
	);

	// stage 2 math: candidate sums and the direct results
	always_comb begin
		ts_w = SUM_W'($signed(ts_raw));
		tp_w = SUM_W'($signed(tp_raw));
		a_w  = SUM_W'(it_s1.alpha);
		ap_w = SUM_W'(ap_s1);
		e1_w = SUM_W'(e_s1);
		x1_c = sat40(ts_w + a_w);
		x2_c = sat40(tp_w + ap_w);
		unique case (ctl_s1.mode)
			MODE_EMIS: dir_c = ALPHA_W'(e_s1);
			MODE_SELF: dir_c = sat40(ts_w + a_w + e1_w);
			MODE_PREV: dir_c = sat40(tp_w + ap_w + e1_w);
			default:   dir_c = '0;
		endcase
	end

	// stage 3 math: distance of the two candidates
	always_comb begin
		if (x1_s2 >= x2_s2) dmag_c = ($signed({x1_s2[ALPHA_W-1], x1_s2}) -
			$signed({x2_s2[ALPHA_W-1], x2_s2}));
		else dmag_c = ($signed({x2_s2[ALPHA_W-1], x2_s2}) -
			$signed({x1_s2[ALPHA_W-1], x1_s2}));
	end

	// stage 4 math: table interpolation
	always_comb begin
		tk_c   = lse_tab({1'b0, k_s3});
		tn_c   = lse_tab({1'b0, k_s3} + 6'd1);
		td_c   = tk_c - tn_c;
		prod_c = td_c * frac_s3;
	end

	// stage 5 and 6 math: correction and emission add
	always_comb begin
		corr_c = tk_s4 - sub_s4;
		lse_c  = far_s4 ? m_s4 : sat40(SUM_W'(m_s4) + SUM_W'(corr_c));
		unique case (ctl_s5.mode)
			MODE_LSE:  res_c = sat40(SUM_W'(lse_s5) + SUM_W'(e_s5));
			MODE_KEEP: res_c = it_s5.alpha;
			default:   res_c = dir_s5;
		endcase
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (shift_en) begin
			it_s1   <= head;
			ap_s1   <= it_s1.alpha;
			e_s1    <= head_emis;
			it_s2   <= it_s1;
			e_s2    <= e_s1;
			x1_s2   <= x1_c;
			x2_s2   <= x2_c;
			dir_s2  <= dir_c;
			it_s3   <= it_s2;
			e_s3    <= e_s2;
			dir_s3  <= dir_s2;
			m_s3    <= (x1_s2 > x2_s2) ? x1_s2 : x2_s2;
			far_s3  <= |dmag_c[ALPHA_W:FRAC_W+3];
			k_s3    <= dmag_c[FRAC_W+2:IFRAC_W];
			frac_s3 <= dmag_c[IFRAC_W-1:0];
			it_s4   <= it_s3;
			e_s4    <= e_s3;
			dir_s4  <= dir_s3;
			m_s4    <= m_s3;
			far_s4  <= far_s3;
			tk_s4   <= tk_c;
			sub_s4  <= prod_c[TAB_W+IFRAC_W-1:IFRAC_W];
			it_s5   <= it_s4;
			e_s5    <= e_s4;
			dir_s5  <= dir_s4;
			lse_s5  <= lse_c;
			it_s6.label <= it_s5.label;
			it_s6.alpha <= res_c;
		end
	end

	// per-slot control travels with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '{mode: MODE_KEEP, cap: 1'b0};
			ctl_s2 <= '{mode: MODE_KEEP, cap: 1'b0};
			ctl_s3 <= '{mode: MODE_KEEP, cap: 1'b0};
			ctl_s4 <= '{mode: MODE_KEEP, cap: 1'b0};
			ctl_s5 <= '{mode: MODE_KEEP, cap: 1'b0};
			ctl_s6 <= '{mode: MODE_KEEP, cap: 1'b0};
		end else if (shift_en) begin
			ctl_s1 <= head_ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
		end
	end

	assign tail     = it_s6;
	assign tail_ctl = ctl_s6;

endmodule

// ===== rtl/force_alignment_log_score.sv =====
// ----------------------------------------------------------------------------
// force_alignment_log_score
// Log-domain forced-alignment forward score over a ring of alpha cells.
//
// Input stream: tuser carries the request kind (label write, transition
// write, emission score), tlast marks the last emission score of a frame.
// Label, transition and ordinary emission beats leave the block idle.
// An emission beat with tlast, when the target is not empty, rotates the
// ring of 64 cells through the six-stage update unit once, one slot per
// cycle: the block is busy until every slot of the ring has passed.
// After the last frame the multiply state forms the scaled score and the
// output state loads it; with an empty target the last frame's beat goes
// straight to the output state, which gives score 0 with status 1.
// Results wait in an output register; the input side stays open while a
// result waits in idle, and stalls whenever the block is not idle, also in
// the output state until the old result is taken.
// Reset returns the frame index to zero and the registers to frame_count
// 1, target_length 0, score_scale 1.0; labels, transitions and emission
// scores must be written before use.
// ----------------------------------------------------------------------------
module force_alignment_log_score import fals_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// position[5:0], label_a[10:6], label_b[15:11], value[39:16]
	input  logic [39:0]  s_axis_tdata,
	input  logic         s_axis_tlast,
	// req_type[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// score[39:0]
	output logic [39:0]  m_axis_tdata,
	// status[0]
	output logic         m_axis_tuser,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [16:0]  cfg_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_ROT, ST_MUL, ST_OUT} state_t;

	state_t state_q;
	logic [ROT_W-1:0] rot_cnt_q;
	logic [CNT_W-1:0] frame_count_q;
	logic [TLEN_W-1:0] target_length_q;
	logic [SCALE_W-1:0] score_scale_q;
	logic [FRAME_W-1:0] frame_idx_q;
	val_t frame_scores_q [MAX_CLASSES];
	logic t0_q, w0_q, hw_q, final_q, empty_q;
	logic [TLEN_W-1:0] len_q, low_q, high_q;
	alpha_t final_alpha_q;
	logic signed [VAL_W+SCALE_W:0] ph_q;
	logic [FRAC_W+SCALE_W-1:0] pl_q;
	logic out_valid_q;
	logic [ALPHA_W-1:0] out_data_q;
	logic out_status_q;

	logic in_acc;
	logic [POS_W-1:0] in_pos;
	logic [CLASS_W-1:0] in_la, in_lb;
	val_t in_val;
	logic [CNT_W-1:0] t_eff, t_cur, rem, t_inc;
	logic [TLEN_W-1:0] l_eff, high_c, low_c;
	logic last_fr;
	logic shift_en;
	item_t chain [MAX_TARGETS];
	item_t ring_tail;
	ctl_t tail_ctl, head_ctl;
	val_t head_emis;
	logic signed [SUM_W-1:0] score_c;

	// beat decode
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign in_pos = s_axis_tdata[5:0];
	assign in_la  = s_axis_tdata[10:6];
	assign in_lb  = s_axis_tdata[15:11];
	assign in_val = s_axis_tdata[39:16];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign shift_en = (state_q == ST_ROT);

	// frame geometry: T, L, t, band edges
	always_comb begin
		if (frame_count_q == '0) t_eff = CNT_W'(1);
		else if (frame_count_q > CNT_W'(MAX_FRAMES)) t_eff = CNT_W'(MAX_FRAMES);
		else t_eff = frame_count_q;
		if (CNT_W'(target_length_q) > t_eff) l_eff = t_eff[TLEN_W-1:0];
		else l_eff = target_length_q;
		if (l_eff > TLEN_W'(MAX_TARGETS)) l_eff = TLEN_W'(MAX_TARGETS);
		if (CNT_W'(frame_idx_q) >= t_eff) t_cur = '0;
		else t_cur = CNT_W'(frame_idx_q);
		rem     = t_eff - t_cur;
		t_inc   = t_cur + CNT_W'(1);
		last_fr = (t_inc >= t_eff);
		if (t_cur < CNT_W'(l_eff)) high_c = t_cur[TLEN_W-1:0];
		else high_c = l_eff;
		if (rem < CNT_W'(l_eff)) low_c = l_eff - rem[TLEN_W-1:0];
		else low_c = TLEN_W'(1);
	end

	// update kind of the slot entering the unit
	always_comb begin
		head_ctl.cap = (rot_cnt_q < ROT_W'(MAX_TARGETS)) &&
			(rot_cnt_q == ROT_W'(len_q - TLEN_W'(1)));
		if (rot_cnt_q >= ROT_W'(MAX_TARGETS)) head_ctl.mode = MODE_KEEP;
		else if (t0_q) head_ctl.mode = (rot_cnt_q == '0) ? MODE_EMIS : MODE_KEEP;
		else if (rot_cnt_q == '0) head_ctl.mode = w0_q ? MODE_SELF : MODE_KEEP;
		else if (rot_cnt_q >= ROT_W'(low_q) && rot_cnt_q < ROT_W'(high_q))
			head_ctl.mode = MODE_LSE;
		else if (hw_q && rot_cnt_q == ROT_W'(high_q)) head_ctl.mode = MODE_PREV;
		else head_ctl.mode = MODE_KEEP;
		head_emis = frame_scores_q[chain[0].label];
	end

	// ring of alpha cells
	for (genvar k = 0; k < MAX_TARGETS; k++) begin : g_cell
		item_t cell_d;
		if (k == MAX_TARGETS - 1) begin : g_last
			assign cell_d = ring_tail;
		end else begin : g_mid
			assign cell_d = chain[k+1];
		end
		fals_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.label_we (in_acc && s_axis_tuser == REQ_LABEL && in_pos == POS_W'(k)),
			.label_in (in_la),
			.d        (cell_d),
			.q        (chain[k])
		);
	end

	fals_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift_en  (shift_en),
		.head      (chain[0]),
		.head_ctl  (head_ctl),
		.head_emis (head_emis),
		.tr_we     (in_acc && s_axis_tuser == REQ_TRANS),
		.tr_addr   ({in_la, in_lb}),
		.tr_data   (in_val),
		.tail      (ring_tail),
		.tail_ctl  (tail_ctl)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q   <= CNT_W'(1);
			target_length_q <= '0;
			score_scale_q   <= SCALE_W'(65536);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_FRAME_COUNT:   frame_count_q   <= cfg_data[CNT_W-1:0];
				REG_TARGET_LENGTH: target_length_q <= cfg_data[TLEN_W-1:0];
				REG_SCORE_SCALE:   score_scale_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// emission buffer of the current frame
	always_ff @(posedge clk) begin
		if (in_acc && s_axis_tuser == REQ_EMIS) frame_scores_q[in_la] <= in_val;
	end

	// final alpha capture and scaling products
	always_ff @(posedge clk) begin
		if (shift_en && tail_ctl.cap) final_alpha_q <= ring_tail.alpha;
		if (state_q == ST_MUL) begin
			ph_q <= $signed(final_alpha_q[ALPHA_W-1:FRAC_W]) * $signed({1'b0, score_scale_q});
			pl_q <= final_alpha_q[FRAC_W-1:0] * score_scale_q;
		end
	end

	assign score_c = SUM_W'(ph_q) + SUM_W'(pl_q[FRAC_W+SCALE_W-1:FRAC_W]);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rot_cnt_q    <= '0;
			frame_idx_q  <= '0;
			t0_q         <= 1'b0;
			w0_q         <= 1'b0;
			hw_q         <= 1'b0;
			final_q      <= 1'b0;
			empty_q      <= 1'b0;
			len_q        <= '0;
			low_q        <= '0;
			high_q       <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_status_q <= 1'b0;
		end else begin
			// a taken beat clears unless the output state reloads it
			if (m_axis_tready && state_q != ST_OUT) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && s_axis_tuser == REQ_EMIS && s_axis_tlast) begin
						frame_idx_q <= last_fr ? '0 : t_inc[FRAME_W-1:0];
						t0_q    <= (t_cur == '0);
						w0_q    <= (rem >= CNT_W'(l_eff));
						hw_q    <= (high_c < l_eff);
						len_q   <= l_eff;
						low_q   <= low_c;
						high_q  <= high_c;
						final_q <= last_fr;
						empty_q <= (l_eff == '0);
						rot_cnt_q <= '0;
						if (l_eff != '0) state_q <= ST_ROT;
						else if (last_fr) state_q <= ST_OUT;
					end
				end
				ST_ROT: begin
					rot_cnt_q <= rot_cnt_q + ROT_W'(1);
					if (rot_cnt_q == ROT_W'(RING_LEN - 1))
						state_q <= final_q ? ST_MUL : ST_IDLE;
				end
				ST_MUL: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q  <= 1'b1;
						out_data_q   <= empty_q ? '0 : sat40(score_c);
						out_status_q <= empty_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;

	// a new result is loaded only from the output state
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result appeared outside the output state");

	// a rotation runs its full ring length
	a_rot_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROT && rot_cnt_q != ROT_W'(RING_LEN - 1)) |=> state_q == ST_ROT)
		else $error("ring rotation ended early");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_data_q)))
		else $error("waiting result was lost");

	// the ring is parked whenever new beats are taken
	a_park: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !shift_en)
		else $error("beat accepted during rotation");

endmodule
